/* rtl/owr_pkg.sv */
package owr_pkg;

    typedef struct packed {
        logic accept_wr;
        logic commit_look;
        logic commit_wr;
        logic rd_len;
        logic rd_issue;
        logic emit_nd;
    } owr_cmd_t;

    typedef struct packed {
        logic empty;
        logic len_zero;
        logic idx_last;
    } owr_status_t;

endpackage

/* rtl/owr_ctrl.sv */
module owr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 action,
    input  logic                 end_of_message,
    input  owr_pkg::owr_status_t status,
    output owr_pkg::owr_cmd_t    cmd,
    output logic                 busy
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_CMT_LOOK  = 6'b000010,
        ST_CMT_WR    = 6'b000100,
        ST_RD_LOOK   = 6'b001000,
        ST_RD_LEN    = 6'b010000,
        ST_RD_STREAM = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (!action)
                    begin
                        cmd.accept_wr = 1'b1;
                        if (end_of_message)
                        begin
                            state_next = ST_CMT_LOOK;
                        end
                    end
                    else if (status.empty)
                    begin
                        cmd.emit_nd = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RD_LOOK;
                    end
                end
            end
            ST_CMT_LOOK:
            begin
                cmd.commit_look = 1'b1;
                state_next      = ST_CMT_WR;
            end
            ST_CMT_WR:
            begin
                cmd.commit_wr = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RD_LOOK:
            begin
                state_next = ST_RD_LEN;
            end
            ST_RD_LEN:
            begin
                cmd.rd_len = 1'b1;
                state_next = status.len_zero ? ST_IDLE : ST_RD_STREAM;
            end
            ST_RD_STREAM:
            begin
                cmd.rd_issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/owr_dp.sv */
module owr_dp
#(
    parameter int SLOTS     = 8,
    parameter int MAX_BYTES = 63
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  owr_pkg::owr_cmd_t    cmd,
    input  logic [7:0]           data_byte,
    input  logic                 byte_valid,
    output owr_pkg::owr_status_t status,
    output logic [7:0]           out_byte,
    output logic                 last_byte,
    output logic                 no_data,
    output logic                 strobe
);

    localparam int SW = $clog2(SLOTS);
    localparam int RW = $clog2(SLOTS + 1);
    localparam int FW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(MAX_BYTES + 1);
    localparam int AW = RW + LW;
    localparam int MSG_DEPTH = 2 ** AW;

    // message rows: one per slot plus one staging row, mapped through the slot table
    logic [7:0]       msg_mem [MSG_DEPTH];
    logic [LW+RW-1:0] slot_mem [SLOTS];

    logic [SW-1:0] write_slot_reg, write_slot_next;
    logic [SW-1:0] read_slot_reg, read_slot_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [LW-1:0] stg_len_reg, stg_len_next;
    logic          stg_stop_reg, stg_stop_next;
    logic [RW-1:0] stg_row_reg, stg_row_next;
    logic          wrapped_reg, wrapped_next;
    logic          res_valid_reg, res_valid_next;

    logic [RW-1:0] rd_row_reg;
    logic [LW-1:0] rd_len_reg;
    logic [LW-1:0] rd_idx_reg;
    logic          res_last_reg;
    logic          res_nd_reg;
    logic [7:0]    msg_q_reg;
    logic [LW+RW-1:0] slot_q_reg;

    logic          byte_store;
    logic [SW-1:0] slot_raddr;
    logic [LW-1:0] slot_q_len;
    logic [RW-1:0] slot_q_row;
    logic [SW-1:0] write_slot_inc;
    logic [SW-1:0] read_slot_inc;

    assign slot_q_len = slot_q_reg[LW+RW-1:RW];
    assign slot_q_row = slot_q_reg[RW-1:0];

    assign write_slot_inc = (write_slot_reg == SW'(SLOTS - 1)) ? '0 : write_slot_reg + 1'b1;
    assign read_slot_inc  = (read_slot_reg == SW'(SLOTS - 1)) ? '0 : read_slot_reg + 1'b1;

    assign byte_store = cmd.accept_wr && byte_valid && !stg_stop_reg && (data_byte != 8'd0)
                        && (stg_len_reg < LW'(MAX_BYTES));

    assign slot_raddr = cmd.commit_look ? write_slot_reg : read_slot_reg;

    assign status.empty    = (fill_reg == '0);
    assign status.len_zero = (slot_q_len == '0);
    assign status.idx_last = (rd_idx_reg == rd_len_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (byte_store)
        begin
            msg_mem[{stg_row_reg, stg_len_reg}] <= data_byte;
        end
        msg_q_reg <= msg_mem[{rd_row_reg, rd_idx_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_wr)
        begin
            slot_mem[write_slot_reg] <= {stg_len_reg, stg_row_reg};
        end
        slot_q_reg <= slot_mem[slot_raddr];
    end

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        fill_next       = fill_reg;
        stg_len_next    = stg_len_reg;
        stg_stop_next   = stg_stop_reg;
        stg_row_next    = stg_row_reg;
        wrapped_next    = wrapped_reg;
        res_valid_next  = cmd.emit_nd || cmd.rd_issue || (cmd.rd_len && status.len_zero);

        if (cmd.accept_wr && byte_valid && !stg_stop_reg)
        begin
            if (data_byte == 8'd0)
            begin
                stg_stop_next = 1'b1;
            end
            else if (byte_store)
            begin
                stg_len_next = stg_len_reg + 1'b1;
            end
        end

        if (cmd.commit_wr)
        begin
            // once wrapped, the overwritten slot's row becomes the next staging row
            stg_row_next    = wrapped_reg ? slot_q_row : RW'(write_slot_reg);
            write_slot_next = write_slot_inc;
            if (write_slot_reg == SW'(SLOTS - 1))
            begin
                wrapped_next = 1'b1;
            end
            if (fill_reg < FW'(SLOTS))
            begin
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                read_slot_next = read_slot_inc;
            end
            stg_len_next  = '0;
            stg_stop_next = 1'b0;
        end

        if (cmd.rd_len)
        begin
            read_slot_next = read_slot_inc;
            fill_next      = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            fill_reg       <= '0;
            stg_len_reg    <= '0;
            stg_stop_reg   <= 1'b0;
            stg_row_reg    <= RW'(SLOTS);
            wrapped_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            fill_reg       <= fill_next;
            stg_len_reg    <= stg_len_next;
            stg_stop_reg   <= stg_stop_next;
            stg_row_reg    <= stg_row_next;
            wrapped_reg    <= wrapped_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_len)
        begin
            rd_row_reg <= slot_q_row;
            rd_len_reg <= slot_q_len;
            rd_idx_reg <= '0;
        end
        else if (cmd.rd_issue)
        begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
        if (res_valid_next)
        begin
            res_last_reg <= cmd.emit_nd || cmd.rd_len || status.idx_last;
            res_nd_reg   <= cmd.emit_nd || cmd.rd_len;
        end
    end

    assign strobe    = res_valid_reg;
    assign last_byte = res_last_reg;
    assign no_data   = res_nd_reg;
    assign out_byte  = res_nd_reg ? 8'd0 : msg_q_reg;

endmodule

/* rtl/overwrite_message_ring_top.sv */
// channel   | handshake               | ports
// ----------+-------------------------+---------------------------------------------
// input     | start & !busy           | action, data_byte, byte_valid, end_of_message
// result    | strobe, one cycle       | out_byte, last_byte, no_data
//
// a write item without end_of_message is taken in idle; with it, the controller then does
// a slot table lookup and a slot table write; a read of an empty ring is answered in idle;
// a read of a stored message steps through the slot table read, the length load and the
// one-byte-per-cycle message memory port; results appear in the cycle after issue
// rst_n clears pointers, counts and staging state at once; memories are not cleared
// the receiver cannot stall: each result is on the ports for exactly one cycle
module overwrite_message_ring_top
#(
    parameter int SLOTS     = 8,
    parameter int MAX_BYTES = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       action,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       end_of_message,
    output logic       strobe,
    output logic [7:0] out_byte,
    output logic       last_byte,
    output logic       no_data
);

    owr_pkg::owr_cmd_t    cmd;
    owr_pkg::owr_status_t status;

    owr_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .action         (action),
        .end_of_message (end_of_message),
        .status         (status),
        .cmd            (cmd),
        .busy           (busy)
    );

    owr_dp
    #(
        .SLOTS     (SLOTS),
        .MAX_BYTES (MAX_BYTES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .out_byte   (out_byte),
        .last_byte  (last_byte),
        .no_data    (no_data),
        .strobe     (strobe)
    );

    a_nd_form: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && no_data |-> last_byte && (out_byte == 8'd0))
        else $error("no-data result malformed");

    a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_byte |=> strobe && !no_data)
        else $error("message stream broke before last byte");

    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_byte |-> busy)
        else $error("idle while message bytes remain");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !action |=> !strobe)
        else $error("result after write item");

endmodule
